@@ hw/rtl/i2cm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, widths and the structs passed between the engine modules.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int DELAY_W = 16;
  localparam int WAIT_W  = 17;
  localparam int STEP_W  = 5;
  localparam int BYTE_W  = 8;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd72;

  // SCL/SDA sequence end points, counted in segments
  localparam logic [STEP_W-1:0] WRITE_END_STEP  = 5'd24;
  localparam logic [STEP_W-1:0] WRITE_LAST_STEP = 5'd23;
  localparam logic [STEP_W-1:0] READ_END_STEP   = 5'd16;

  // step / 3 for steps below 24 as (step * 11) >> 5
  localparam logic [3:0] RECIP_3 = 4'd11;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_ACK    = 3'd5,
    CMD_NACK   = 3'd6,
    CMD_CHKACK = 3'd7
  } cmd_t;

  // wait after a segment, in delay units
  typedef enum logic [1:0] {
    UNITS_END = 2'd0,
    UNITS_ONE = 2'd1,
    UNITS_TWO = 2'd2
  } units_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [STEP_W-1:0] step;
    logic [BYTE_W-1:0] shift;
    logic              sda_in;
    logic              scl;
    logic              sda;
  } seg_in_t;

  typedef struct packed {
    units_t            units;
    logic              scl;
    logic              sda;
    logic [BYTE_W-1:0] shift;
    logic              rx_we;
    logic              nack_we;
    logic              nack_val;
  } seg_out_t;

  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_failed;
  } seq_res_t;

endpackage

@@ hw/rtl/i2cm_seg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master segment decoder
// Gives the line levels, shift update and wait length of one segment.
// ----------------------------------------------------------------------------
module i2cm_seg (
  input  i2cm_pkg::seg_in_t  seg_i,
  output i2cm_pkg::seg_out_t seg_o
);
  import i2cm_pkg::*;

  logic [8:0]        prod;
  logic [2:0]        bit_idx;
  logic [STEP_W-1:0] phase;

  assign prod    = 9'(seg_i.step) * 9'(RECIP_3);
  assign bit_idx = prod[7:5];
  assign phase   = seg_i.step - {1'b0, bit_idx, 1'b0} - {2'b00, bit_idx};

  always_comb begin
    seg_o          = '0;
    seg_o.units    = UNITS_END;
    seg_o.scl      = seg_i.scl;
    seg_o.sda      = seg_i.sda;
    seg_o.shift    = seg_i.shift;
    seg_o.rx_we    = 1'b0;
    seg_o.nack_we  = 1'b0;
    seg_o.nack_val = seg_i.sda_in;
    unique case (seg_i.cmd)
      CMD_START: begin
        if (seg_i.step == 5'd0) begin
          seg_o.sda   = 1'b1;
          seg_o.scl   = 1'b1;
          seg_o.units = UNITS_ONE;
        end else if (seg_i.step == 5'd1) begin
          seg_o.sda   = 1'b0;
          seg_o.units = UNITS_ONE;
        end else if (seg_i.step == 5'd2) begin
          seg_o.scl   = 1'b0;
          seg_o.units = UNITS_ONE;
        end
      end
      CMD_STOP: begin
        if (seg_i.step == 5'd0) begin
          seg_o.sda   = 1'b0;
          seg_o.scl   = 1'b1;
          seg_o.units = UNITS_TWO;
        end else begin
          seg_o.sda = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (seg_i.step < WRITE_END_STEP) begin
          seg_o.units = UNITS_TWO;
          if (phase == 5'd0) begin
            seg_o.sda = seg_i.shift[BYTE_W-1];
          end else if (phase == 5'd1) begin
            seg_o.scl = 1'b1;
          end else begin
            seg_o.scl   = 1'b0;
            // release SDA after the last data bit
            if (seg_i.step == WRITE_LAST_STEP) begin
              seg_o.sda = 1'b1;
            end
            seg_o.shift = {seg_i.shift[BYTE_W-2:0], 1'b0};
          end
        end
      end
      CMD_READ: begin
        if (seg_i.step >= READ_END_STEP) begin
          seg_o.rx_we = 1'b1;
        end else if (!seg_i.step[0]) begin
          if (seg_i.step == 5'd0) begin
            seg_o.sda   = 1'b1;
            seg_o.shift = '0;
          end
          seg_o.scl   = 1'b1;
          seg_o.units = UNITS_ONE;
        end else begin
          seg_o.shift = {seg_i.shift[BYTE_W-2:0], seg_i.sda_in};
          seg_o.scl   = 1'b0;
          seg_o.units = UNITS_ONE;
        end
      end
      CMD_ACK: begin
        if (seg_i.step == 5'd0) begin
          seg_o.sda   = 1'b0;
          seg_o.units = UNITS_TWO;
        end else if (seg_i.step == 5'd1) begin
          seg_o.scl   = 1'b1;
          seg_o.units = UNITS_TWO;
        end else if (seg_i.step == 5'd2) begin
          seg_o.scl   = 1'b0;
          seg_o.units = UNITS_TWO;
        end else begin
          seg_o.sda = 1'b1;
        end
      end
      CMD_NACK, CMD_CHKACK: begin
        if (seg_i.step == 5'd0) begin
          seg_o.sda   = 1'b1;
          seg_o.units = UNITS_ONE;
        end else if (seg_i.step == 5'd1) begin
          seg_o.scl   = 1'b1;
          seg_o.units = UNITS_ONE;
        end else if (seg_i.step == 5'd2) begin
          seg_o.scl     = 1'b0;
          seg_o.nack_we = (seg_i.cmd == CMD_CHKACK);
          seg_o.units   = UNITS_ONE;
        end
      end
      CMD_NONE: begin
        seg_o.units = UNITS_END;
      end
    endcase
  end

endmodule

@@ hw/rtl/i2cm_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer
// Holds command, step and wait state and advances it by one tick per call.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic [i2cm_pkg::DELAY_W-1:0]    delay_ticks,
  input  logic [2:0]                      func,
  input  logic [i2cm_pkg::BYTE_W-1:0]     tx_byte,
  input  logic                            sda_in,
  output i2cm_pkg::seq_res_t              res
);
  import i2cm_pkg::*;

  cmd_t              cmd_r, cmd_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic [BYTE_W-1:0] rx_r, rx_nxt;
  logic              nack_r, nack_nxt;
  logic              done;

  cmd_t              cmd_a;
  logic [STEP_W-1:0] step_a;
  logic [BYTE_W-1:0] shift_a;
  logic [WAIT_W-1:0] wait_a;
  logic              run;
  logic [DELAY_W-1:0] dly;
  seg_in_t           seg_in;
  seg_out_t          seg_out;

  assign dly = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;

  // accept a new command when idle, otherwise count down the wait
  always_comb begin
    cmd_a   = cmd_r;
    step_a  = step_r;
    shift_a = shift_r;
    wait_a  = wait_r;
    run     = 1'b0;
    if (cmd_r == CMD_NONE) begin
      if (func != 3'd0) begin
        cmd_a  = cmd_t'(func);
        step_a = '0;
        if (cmd_t'(func) == CMD_WRITE) begin
          shift_a = tx_byte;
        end
        run = 1'b1;
      end
    end else begin
      if (wait_r != '0) begin
        wait_a = wait_r - WAIT_W'(1);
      end
      if (wait_a == '0) begin
        step_a = step_r + STEP_W'(1);
        run    = 1'b1;
      end
    end
  end

  assign seg_in = '{cmd: cmd_a, step: step_a, shift: shift_a, sda_in: sda_in,
                    scl: scl_r, sda: sda_r};

  i2cm_seg u_seg (
    .seg_i (seg_in),
    .seg_o (seg_out)
  );

  // next state
  always_comb begin
    cmd_nxt   = cmd_a;
    step_nxt  = step_a;
    wait_nxt  = wait_a;
    shift_nxt = shift_a;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    rx_nxt    = rx_r;
    nack_nxt  = nack_r;
    done      = 1'b0;
    if (run) begin
      scl_nxt   = seg_out.scl;
      sda_nxt   = seg_out.sda;
      shift_nxt = seg_out.shift;
      if (seg_out.rx_we) begin
        rx_nxt = shift_a;
      end
      if (seg_out.nack_we) begin
        nack_nxt = seg_out.nack_val;
      end
      if (seg_out.units == UNITS_END) begin
        cmd_nxt  = CMD_NONE;
        step_nxt = '0;
        wait_nxt = '0;
        done     = 1'b1;
      end else if (seg_out.units == UNITS_TWO) begin
        wait_nxt = {dly, 1'b0};
      end else begin
        wait_nxt = {1'b0, dly};
      end
    end
  end

  // result of this tick
  always_comb begin
    res.scl        = scl_nxt;
    res.sda        = sda_nxt;
    res.busy       = (cmd_nxt != CMD_NONE);
    res.done       = done;
    res.rx_byte    = rx_nxt;
    res.ack_failed = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_NONE;
      step_r  <= '0;
      wait_r  <= '0;
      shift_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      rx_r    <= '0;
      nack_r  <= 1'b0;
    end else if (adv) begin
      cmd_r   <= cmd_nxt;
      step_r  <= step_nxt;
      wait_r  <= wait_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      rx_r    <= rx_nxt;
      nack_r  <= nack_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r == CMD_NONE |-> step_r == '0 && wait_r == '0)
    else $error("idle sequencer holds a step or wait count");

  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wait_r != '0 |-> cmd_r != CMD_NONE)
    else $error("wait count running while idle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && done |=> cmd_r == CMD_NONE)
    else $error("command finished but sequencer not idle");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cmd_r) && $stable(step_r) && $stable(wait_r))
    else $error("sequencer state moved without a tick");

  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r == CMD_WRITE |-> step_r < WRITE_END_STEP)
    else $error("write step out of range");
`endif

endmodule

@@ hw/rtl/i2c_master_bit_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// An accepted tick is held in the input register, its result in the result register.
// Throughput: one tick per cycle while results are taken; a stalled result
// holds the input register, so one more tick is taken and then input waits.
// Reset (rst_n low, synchronous): engine idle, SCL/SDA released, delay 72.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [i2cm_pkg::DELAY_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_func,
  input  logic [i2cm_pkg::BYTE_W-1:0]      in_tx_byte,
  input  logic                             in_sda_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_scl_out,
  output logic                             out_sda_out,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic [i2cm_pkg::BYTE_W-1:0]      out_rx_byte,
  output logic                             out_ack_failed
);
  import i2cm_pkg::*;

  logic [DELAY_W-1:0] delay_r;
  logic               in_vld_r, in_vld_nxt;
  logic [2:0]         func_r;
  logic [BYTE_W-1:0]  tx_r;
  logic               sdain_r;
  logic               out_vld_r, out_vld_nxt;
  seq_res_t           res;
  seq_res_t           res_r;
  logic               adv;
  logic               in_xfer;

  assign cfg_ready = 1'b1;

  // advance when a tick is held and the result slot is free or draining
  assign adv        = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !in_vld_r || adv;
  assign in_xfer    = in_valid && in_ready;
  assign in_vld_nxt = in_xfer || (in_vld_r && !adv);
  assign out_vld_nxt = adv || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r   <= DELAY_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delay_r <= cfg_data;
      end
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r  <= in_func;
      tx_r    <= in_tx_byte;
      sdain_r <= in_sda_in;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  i2cm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .delay_ticks (delay_r),
    .func        (func_r),
    .tx_byte     (tx_r),
    .sda_in      (sdain_r),
    .res         (res)
  );

  assign out_valid      = out_vld_r;
  assign out_scl_out    = res_r.scl;
  assign out_sda_out    = res_r.sda;
  assign out_busy_res   = res_r.busy;
  assign out_done_res   = res_r.done;
  assign out_rx_byte    = res_r.rx_byte;
  assign out_ack_failed = res_r.ack_failed;

endmodule
